// ----- sv/rgbhsv_pkg.sv -----
// Shared types and constants for the RGB to HSV converter.
package rgbhsv_pkg;

  localparam int CH_BITS   = 8;
  localparam int CMAX      = (1 << CH_BITS) - 1;
  localparam int HUE_W     = 15;
  localparam int DIV_STEPS = (CH_BITS > 12) ? CH_BITS : 12;
  localparam int REM_W     = CH_BITS + DIV_STEPS + 1;

  localparam logic [HUE_W-1:0] HUE_0   = HUE_W'(0);
  localparam logic [HUE_W-1:0] HUE_120 = HUE_W'(120 * 64);
  localparam logic [HUE_W-1:0] HUE_240 = HUE_W'(240 * 64);
  localparam logic [HUE_W-1:0] HUE_360 = HUE_W'(360 * 64);

  localparam int MID_DEPTH_DEF = 4;
  localparam int OUT_DEPTH_DEF = 32;

  typedef struct packed {
    logic [CH_BITS-1:0] red;
    logic [CH_BITS-1:0] green;
    logic [CH_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0]   hue;
    logic               hue_defined;
    logic [CH_BITS-1:0] saturation;
    logic [CH_BITS-1:0] brightness;
  } hsv_t;

  // classified pixel: sector base, sign and magnitude of the difference
  typedef struct packed {
    logic               defined;
    logic               neg;
    logic [HUE_W-1:0]   base;
    logic [CH_BITS-1:0] brightness;
    logic [CH_BITS-1:0] delta;
    logic [CH_BITS-1:0] absdiff;
  } class_t;

  typedef struct packed {
    class_t               c;
    logic [REM_W-1:0]     rem_h;
    logic [REM_W-1:0]     rem_s;
    logic [DIV_STEPS-1:0] q_h;
    logic [DIV_STEPS-1:0] q_s;
  } div_t;

endpackage

// ----- sv/rgbhsv_fifo.sv -----
// Small register FIFO used between the pipeline parts.
module rgbhsv_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty,
  output logic         full
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign empty   = (cnt_r == CW'(0));
  assign full    = (cnt_r == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (do_pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end
endmodule

// ----- sv/rgbhsv_front.sv -----
// Front part: takes a pixel, finds max/min, sector and hue difference.
module rgbhsv_front import rgbhsv_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_push,
  output logic   in_full,
  input  pixel_t in_word,
  output logic   cls_valid,
  input  logic   cls_ready,
  output class_t cls_word
);
  logic   v_r;
  class_t c_r, c_nxt;
  logic   take;
  logic [CH_BITS-1:0] r, g, b, mx, mn, pa, pb;

  assign in_full   = v_r && !cls_ready;
  assign take      = in_push && !in_full;
  assign cls_valid = v_r;
  assign cls_word  = c_r;

  always_comb begin
    r = in_word.red;
    g = in_word.green;
    b = in_word.blue;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    // red wins ties, then green
    if (r >= g && r >= b) begin
      mx = r; pa = g; pb = b;
    end else if (g >= b) begin
      mx = g; pa = b; pb = r;
    end else begin
      mx = b; pa = r; pb = g;
    end
    c_nxt.brightness = mx;
    c_nxt.delta      = mx - mn;
    c_nxt.defined    = (mx != mn);
    c_nxt.neg        = (pa < pb);
    c_nxt.absdiff    = (pa < pb) ? (pb - pa) : (pa - pb);
    if (r >= g && r >= b)  c_nxt.base = (pa < pb) ? HUE_360 : HUE_0;
    else if (g >= b)       c_nxt.base = HUE_120;
    else                   c_nxt.base = HUE_240;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (take) begin
      v_r <= 1'b1;
    end else if (cls_ready) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) c_r <= c_nxt;
  end
endmodule

// ----- sv/rgbhsv_back.sv -----
// Back part: two restoring dividers, one quotient bit per stage, then hue fixup.
module rgbhsv_back import rgbhsv_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   issue,
  input  class_t cls_word,
  output logic   res_valid,
  output hsv_t   res_word
);
  logic v_r [DIV_STEPS+1];
  div_t s_r [DIV_STEPS+1];
  div_t s0_nxt;
  logic vf_r;
  hsv_t f_r, f_nxt;

  always_comb begin
    s0_nxt.c     = cls_word;
    // 3840*absdiff and CMAX*delta by shift and subtract
    s0_nxt.rem_h = (REM_W'(cls_word.absdiff) << 12) - (REM_W'(cls_word.absdiff) << 8);
    s0_nxt.rem_s = (REM_W'(cls_word.delta) << CH_BITS) - REM_W'(cls_word.delta);
    s0_nxt.q_h   = '0;
    s0_nxt.q_s   = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else        v_r[0] <= issue;
  end
  always_ff @(posedge clk) begin
    s_r[0] <= s0_nxt;
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    localparam int BIT = DIV_STEPS - k;
    div_t nx;
    logic [REM_W-1:0] dh, ds;
    always_comb begin
      nx = s_r[k-1];
      dh = REM_W'(s_r[k-1].c.delta) << BIT;
      ds = REM_W'(s_r[k-1].c.brightness) << BIT;
      if (s_r[k-1].rem_h >= dh) begin
        nx.rem_h  = s_r[k-1].rem_h - dh;
        nx.q_h[BIT] = 1'b1;
      end
      if (s_r[k-1].rem_s >= ds) begin
        nx.rem_s  = s_r[k-1].rem_s - ds;
        nx.q_s[BIT] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else        v_r[k] <= v_r[k-1];
    end
    always_ff @(posedge clk) begin
      s_r[k] <= nx;
    end
  end

  always_comb begin
    div_t d;
    logic [HUE_W-1:0] q;
    d = s_r[DIV_STEPS];
    q = HUE_W'(d.q_h);
    f_nxt.brightness  = d.c.brightness;
    f_nxt.hue_defined = d.c.defined;
    f_nxt.saturation  = (d.c.brightness == '0) ? '0 : d.q_s[CH_BITS-1:0];
    // negative difference: floor rounds away from the base
    if (!d.c.defined)  f_nxt.hue = '0;
    else if (d.c.neg)  f_nxt.hue = d.c.base - q - HUE_W'(d.rem_h != '0);
    else               f_nxt.hue = d.c.base + q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vf_r <= 1'b0;
    else        vf_r <= v_r[DIV_STEPS];
  end
  always_ff @(posedge clk) begin
    f_r <= f_nxt;
  end

  assign res_valid = vf_r;
  assign res_word  = f_r;
endmodule

// ----- sv/rgb_to_hsv_core.sv -----
// Top level of the RGB to HSV converter.
// Usage:
//   Input channel: drive in_word and raise in_push; a word is taken on a
//   clock edge where in_push is high and in_full is low.
//   Result channel: while out_empty is low, out_word holds the oldest
//   result; it is taken on an edge where out_pop is high.
//   One word in, one word out, in order.
// Throughput: one pixel per clock when the receiver keeps popping.
// Path from accept to out_empty low: front register, mid queue, restoring
//   divider stages (one quotient bit per stage), hue fixup register, result FIFO.
// The front classifier feeds a MID_DEPTH queue; words leave it only when
//   the OUT_DEPTH result FIFO has a free slot counting words still in the
//   divider, so the divider pipeline never stalls.
// Stall: if out_pop stays low the result FIFO fills, then the mid queue,
//   then in_full rises. Nothing is dropped.
// Reset (rst_n low, synchronous): all queues are emptied, in_full low and
//   out_empty high on the next cycle.
module rgb_to_hsv_core import rgbhsv_pkg::*; #(
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_push,
  output logic   in_full,
  input  pixel_t in_word,
  output logic   out_empty,
  input  logic   out_pop,
  output hsv_t   out_word
);
  localparam int CW = $clog2(OUT_DEPTH + 1);

  logic   cls_valid, mid_full, mid_empty, issue, res_valid, out_full;
  class_t cls_word, mid_word;
  hsv_t   res_word;
  logic [CW-1:0] cred_r;
  logic   pop_ok;

  rgbhsv_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_word,
    .cls_valid, .cls_ready(!mid_full), .cls_word
  );

  rgbhsv_fifo #(.W($bits(class_t)), .DEPTH(MID_DEPTH)) u_mid (
    .clk, .rst_n,
    .push(cls_valid), .wdata(cls_word),
    .pop(issue), .rdata(mid_word),
    .empty(mid_empty), .full(mid_full)
  );

  // words in the divider plus words in the result FIFO
  assign pop_ok = out_pop && !out_empty;
  assign issue  = !mid_empty && (cred_r < CW'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) cred_r <= '0;
    else        cred_r <= cred_r + CW'(issue) - CW'(pop_ok);
  end

  rgbhsv_back u_back (
    .clk, .rst_n, .issue, .cls_word(mid_word), .res_valid, .res_word
  );

  rgbhsv_fifo #(.W($bits(hsv_t)), .DEPTH(OUT_DEPTH)) u_out (
    .clk, .rst_n,
    .push(res_valid), .wdata(res_word),
    .pop(out_pop), .rdata(out_word),
    .empty(out_empty), .full(out_full)
  );

  logic unused_full;
  assign unused_full = out_full;
endmodule

// ----- sv/rgbhsv_checker.sv -----
// Port-level checks for the RGB to HSV converter, bound to the top level.
module rgbhsv_checker import rgbhsv_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  input logic   in_push,
  input logic   in_full,
  input logic   out_empty,
  input logic   out_pop,
  input hsv_t   out_word
);
  logic [15:0] pend_r;
  logic        in_acc, out_acc;

  assign in_acc  = in_push && !in_full;
  assign out_acc = out_pop && !out_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= '0;
    else        pend_r <= pend_r + 16'(in_acc) - 16'(out_acc);
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> pend_r != 16'd0)
    else $error("result word without a pending pixel");
  a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_word.hue_defined) |->
      (out_word.hue == '0 && out_word.saturation == '0))
    else $error("gray pixel with nonzero hue or saturation");
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_word.hue < HUE_360)
    else $error("hue out of range");
endmodule

bind rgb_to_hsv_core rgbhsv_checker u_chk (
  .clk, .rst_n, .in_push, .in_full, .out_empty, .out_pop, .out_word
);
